// ===== rtl/gbr_pkg.sv =====
// Shared constants, control word types and the microcode table of the glyph row renderer.
`timescale 1ns / 1ps

package gbr_pkg;

  localparam int STORE_BYTES      = 4096;
  localparam int MAX_GLYPH_WIDTH  = 64;
  localparam int MAX_GLYPH_HEIGHT = 64;
  localparam int HEADER_BYTES     = 6;

  localparam int STORE_AW = $clog2(STORE_BYTES);
  // The walk pointer must hold a store address plus the largest record skip.
  localparam int PTR_W    = ((STORE_AW > 13) ? STORE_AW : 13) + 1;
  // Bit offset inside a bitmap: rows times stored width plus one column run.
  localparam int BIT_W    = $clog2(MAX_GLYPH_HEIGHT * 255 + MAX_GLYPH_WIDTH + 8);
  localparam int COL_W    = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int ROW_W    = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int STEP_W   = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CODE     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_WIDTH    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_HEIGHT   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SKIP     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_XOFF_RD  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_XOFF     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_YOFF     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ADVANCE  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_ROW_INIT = 4'd10;
  localparam logic [STEP_W-1:0] STEP_BYTE_RD  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_MERGE    = 4'd12;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd13;
  localparam logic [STEP_W-1:0] STEP_NEXT_ROW = 4'd14;
  localparam logic [STEP_W-1:0] STEP_MISS     = 4'd15;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_HDR,
    RD_BMP
  } rd_e;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_CODE,
    LD_W,
    LD_H,
    LD_XO,
    LD_YO,
    LD_ADV
  } ld_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_SKIP,
    ACT_HIT,
    ACT_ROW_INIT,
    ACT_MERGE,
    ACT_EMIT_ROW,
    ACT_EMIT_MISS
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_DRAW,
    C_PTR_OOR,
    C_CODE_ZERO,
    C_CODE_HIT,
    C_H_ZERO,
    C_DW_ZERO,
    C_COL_MORE,
    C_ROW_LAST
  } cond_e;

  typedef struct packed {
    logic              accept_in;
    logic              wait_out;
    rd_e               rd;
    logic [2:0]        hdr_off;
    ld_e               ld;
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic draw_start;
    logic stall;
    logic ptr_oor;
    logic code_zero;
    logic code_hit;
    logic h_zero;
    logic dw_zero;
    logic col_more;
    logic row_last;
  } status_t;

  // Microcode table: one control word per step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c           = '0;
    c.rd        = RD_NONE;
    c.ld        = LD_NONE;
    c.act       = ACT_NONE;
    c.cond      = C_NEVER;
    c.target    = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        c.accept_in = 1'b1;
        c.act       = ACT_START;
        c.cond      = C_NO_DRAW;
        c.target    = STEP_IDLE;
      end
      STEP_CHECK: begin
        c.rd      = RD_HDR;
        c.hdr_off = 3'd0;
        c.cond    = C_PTR_OOR;
        c.target  = STEP_MISS;
      end
      STEP_CODE: begin
        c.rd      = RD_HDR;
        c.hdr_off = 3'd1;
        c.ld      = LD_CODE;
      end
      STEP_WIDTH: begin
        c.rd      = RD_HDR;
        c.hdr_off = 3'd2;
        c.ld      = LD_W;
        c.cond    = C_CODE_ZERO;
        c.target  = STEP_MISS;
      end
      STEP_HEIGHT: begin
        c.ld     = LD_H;
        c.cond   = C_CODE_HIT;
        c.target = STEP_XOFF_RD;
      end
      STEP_SKIP: begin
        c.act    = ACT_SKIP;
        c.cond   = C_ALWAYS;
        c.target = STEP_CHECK;
      end
      STEP_XOFF_RD: begin
        c.rd      = RD_HDR;
        c.hdr_off = 3'd3;
      end
      STEP_XOFF: begin
        c.rd      = RD_HDR;
        c.hdr_off = 3'd4;
        c.ld      = LD_XO;
      end
      STEP_YOFF: begin
        c.rd      = RD_HDR;
        c.hdr_off = 3'd5;
        c.ld      = LD_YO;
      end
      STEP_ADVANCE: begin
        c.ld     = LD_ADV;
        c.act    = ACT_HIT;
        c.cond   = C_H_ZERO;
        c.target = STEP_EMIT;
      end
      STEP_ROW_INIT: begin
        c.act    = ACT_ROW_INIT;
        c.cond   = C_DW_ZERO;
        c.target = STEP_EMIT;
      end
      STEP_BYTE_RD: begin
        c.rd = RD_BMP;
      end
      STEP_MERGE: begin
        c.act    = ACT_MERGE;
        c.cond   = C_COL_MORE;
        c.target = STEP_BYTE_RD;
      end
      STEP_EMIT: begin
        c.wait_out = 1'b1;
        c.act      = ACT_EMIT_ROW;
        c.cond     = C_ROW_LAST;
        c.target   = STEP_IDLE;
      end
      STEP_NEXT_ROW: begin
        c.cond   = C_ALWAYS;
        c.target = STEP_ROW_INIT;
      end
      STEP_MISS: begin
        c.wait_out = 1'b1;
        c.act      = ACT_EMIT_MISS;
        c.cond     = C_ALWAYS;
        c.target   = STEP_IDLE;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/gbr_store.sv =====
// Glyph store: byte-wide single-port memory with registered read and out-of-range zero fill.
`timescale 1ns / 1ps

module gbr_store import gbr_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PTR_W-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0]          mem [STORE_BYTES];
  logic [7:0]          rdata_q;
  logic                oor_q;
  logic                in_range;
  logic [STORE_AW-1:0] idx;

  assign in_range = addr_i < PTR_W'(STORE_BYTES);
  assign idx      = addr_i[STORE_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i && in_range) begin
      mem[idx] <= wdata_i;
    end
    rdata_q <= mem[idx];
    oor_q   <= !in_range;
  end

  // Addresses past the end of the store read as zero.
  assign rdata_o = oor_q ? 8'd0 : rdata_q;

endmodule

// ===== rtl/gbr_seq.sv =====
// Microcode sequencer: step counter, control word lookup and conditional jumps.
`timescale 1ns / 1ps

module gbr_seq import gbr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              taken;

  assign ctrl_o = ucode(step_q);

  always_comb begin
    unique case (ctrl_o.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_DRAW:   taken = !status_i.draw_start;
      C_PTR_OOR:   taken = status_i.ptr_oor;
      C_CODE_ZERO: taken = status_i.code_zero;
      C_CODE_HIT:  taken = status_i.code_hit;
      C_H_ZERO:    taken = status_i.h_zero;
      C_DW_ZERO:   taken = status_i.dw_zero;
      C_COL_MORE:  taken = status_i.col_more;
      C_ROW_LAST:  taken = status_i.row_last;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    if (status_i.stall) begin
      step_d = step_q;
    end else if (taken) begin
      step_d = ctrl_o.target;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/gbr_dp.sv =====
// Datapath: walk pointer, glyph header registers, row mask assembly and the output word register.
`timescale 1ns / 1ps

module gbr_dp import gbr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output status_t            status_o,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [11:0]        store_address_i,
  input  logic [7:0]         store_byte_i,
  input  logic signed [15:0] origin_x_i,
  input  logic signed [15:0] origin_y_i,
  input  logic [7:0]         char_code_i,
  input  logic [23:0]        pixel_color_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic signed [16:0] row_x_o,
  output logic signed [16:0] row_y_o,
  output logic [63:0]        row_mask_o,
  output logic [23:0]        row_color_o,
  output logic [7:0]         advance_o,
  output logic               last_row_o
);

  logic             in_fire, stall, go, store_we;
  logic [PTR_W-1:0] rd_addr, store_addr, ptr_skip;
  logic [7:0]       rdata;
  logic [15:0]      area;

  logic [7:0]       want_q, code_q, w_q, h_q, xo_q, yo_q, adv_q;
  logic [23:0]      color_q;
  logic [15:0]      ox_q, oy_q;
  logic [PTR_W-1:0] ptr_q;
  logic [ROW_W-1:0] row_q, row_inc, dh;
  logic [BIT_W-1:0] row_base_q, b_q;
  logic [COL_W-1:0] col_q, dw, col_rem, col_next;
  logic [63:0]      mask_q, mask_next;

  logic [2:0]       bit_off;
  logic [7:0]       aligned, rev, sel;
  logic [3:0]       avail, take;

  logic             emit_row, emit_miss, out_valid_q;
  logic [16:0]      cur_x, cur_y;

  assign in_ready_o = ctrl_i.accept_in;
  assign in_fire    = in_valid_i && ctrl_i.accept_in;
  assign store_we   = in_fire && !mode_i;
  assign stall      = ctrl_i.wait_out && out_valid_q && !out_ready_i;
  assign go         = !stall;

  always_comb begin
    case (ctrl_i.rd)
      RD_HDR:  rd_addr = ptr_q + PTR_W'(ctrl_i.hdr_off);
      RD_BMP:  rd_addr = ptr_q + PTR_W'(HEADER_BYTES) + PTR_W'(b_q >> 3);
      default: rd_addr = ptr_q;
    endcase
  end

  assign store_addr = store_we ? PTR_W'(store_address_i) : rd_addr;

  gbr_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .addr_i  (store_addr),
    .wdata_i (store_byte_i),
    .rdata_o (rdata)
  );

  // Record skip: six header bytes plus the full bitmap byte count.
  assign area     = 16'({8'd0, w_q} * {8'd0, h_q});
  assign ptr_skip = ptr_q + PTR_W'(HEADER_BYTES) + PTR_W'((area + 16'd7) >> 3);

  assign dw      = (w_q >= 8'(MAX_GLYPH_WIDTH))  ? COL_W'(MAX_GLYPH_WIDTH)  : COL_W'(w_q);
  assign dh      = (h_q >= 8'(MAX_GLYPH_HEIGHT)) ? ROW_W'(MAX_GLYPH_HEIGHT) : ROW_W'(h_q);
  assign row_inc = row_q + ROW_W'(1);

  // One bitmap byte covers the columns from the current bit up to its byte boundary.
  assign bit_off = b_q[2:0];
  assign aligned = rdata << bit_off;
  assign avail   = 4'd8 - {1'b0, bit_off};
  assign col_rem = dw - col_q;
  assign take    = (col_rem < COL_W'(avail)) ? 4'(col_rem) : avail;
  assign sel     = 8'((9'd1 << take) - 9'd1);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rev[k] = aligned[7-k];
    end
  end

  assign mask_next = mask_q | ({56'd0, rev & sel} << col_q);
  assign col_next  = col_q + COL_W'(take);

  always_ff @(posedge clk_i) begin
    if (in_fire && mode_i) begin
      want_q  <= char_code_i;
      color_q <= pixel_color_i;
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      ptr_q   <= '0;
    end
    if (go) begin
      case (ctrl_i.ld)
        LD_CODE: code_q <= rdata;
        LD_W:    w_q    <= rdata;
        LD_H:    h_q    <= rdata;
        LD_XO:   xo_q   <= rdata;
        LD_YO:   yo_q   <= rdata;
        LD_ADV:  adv_q  <= rdata;
        default: ;
      endcase
      case (ctrl_i.act)
        ACT_SKIP: begin
          ptr_q <= ptr_skip;
        end
        ACT_HIT: begin
          row_q      <= '0;
          row_base_q <= '0;
          mask_q     <= '0;
        end
        ACT_ROW_INIT: begin
          col_q  <= '0;
          b_q    <= row_base_q;
          mask_q <= '0;
        end
        ACT_MERGE: begin
          mask_q <= mask_next;
          col_q  <= col_next;
          b_q    <= b_q + BIT_W'(take);
        end
        ACT_EMIT_ROW: begin
          row_q      <= row_inc;
          row_base_q <= row_base_q + BIT_W'(w_q);
        end
        default: ;
      endcase
    end
  end

  assign emit_row  = go && (ctrl_i.act == ACT_EMIT_ROW);
  assign emit_miss = go && (ctrl_i.act == ACT_EMIT_MISS);

  assign cur_x = {ox_q[15], ox_q} + {9'd0, xo_q};
  assign cur_y = {oy_q[15], oy_q} + {9'd0, yo_q} + 17'(row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_row || emit_miss) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_row) begin
      found_o     <= 1'b1;
      row_x_o     <= cur_x;
      row_y_o     <= cur_y;
      row_mask_o  <= mask_q;
      row_color_o <= color_q;
      advance_o   <= adv_q;
      last_row_o  <= status_o.row_last;
    end else if (emit_miss) begin
      found_o     <= 1'b0;
      row_x_o     <= '0;
      row_y_o     <= '0;
      row_mask_o  <= '0;
      row_color_o <= '0;
      advance_o   <= '0;
      last_row_o  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.draw_start = in_fire && mode_i;
  assign status_o.stall      = stall;
  assign status_o.ptr_oor    = ptr_q >= PTR_W'(STORE_BYTES);
  assign status_o.code_zero  = code_q == 8'd0;
  assign status_o.code_hit   = code_q == want_q;
  assign status_o.h_zero     = h_q == 8'd0;
  assign status_o.dw_zero    = w_q == 8'd0;
  assign status_o.col_more   = col_next < dw;
  assign status_o.row_last   = (row_inc == dh) || (dh == '0);

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_row || emit_miss) |-> (!out_valid_q || out_ready_i))
    else $error("result word issued over a pending word");

  a_code_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.ld == LD_CODE) |-> (ptr_q < PTR_W'(STORE_BYTES)))
    else $error("record code read past the end of the store");

  a_merge_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && ctrl_i.act == ACT_MERGE) |=> (col_q > $past(col_q)))
    else $error("bitmap merge did not advance the column");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_row |-> ((row_q < dh) || (dh == '0)))
    else $error("row emitted beyond the drawn height");

endmodule

// ===== rtl/bitmap_glyph_row_renderer.sv =====
// Top level of the bitmap glyph row renderer: stream ports, sequencer and datapath.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                      Word contents
//  s_axis    in         s_axis_tvalid_i/tready_o       tuser: mode; tdata: store write / draw
//  m_axis    out        m_axis_tvalid_o/tready_i       tuser: found; tdata: row; tlast: last row
//
//  A draw walks the records from address 0: a record passed over runs check, code, width,
//  height and skip; a match then reads x offset, y offset and advance; a miss follows the check
//  at the store's end or the width step on a zero code. A row runs row init, a read and a merge
//  per bitmap byte on the single store port (at most nine for 64 columns), emit and,
//  but for the last row, next row. Reset clears the sequencer and the output valid flag but not
//  the store. A full output register holds the sequencer only on the step that issues a word.

module bitmap_glyph_row_renderer import gbr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // store_address[11:0], store_byte[19:12], origin_x[35:20], origin_y[51:36],
  // char_code[59:52], pixel_color[83:60], zero fill[87:84]
  input  logic [87:0]  s_axis_tdata_i,
  // mode[0]
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // row_x[16:0], row_y[33:17], row_mask[97:34], row_color[121:98], advance[129:122],
  // zero fill[135:130]
  output logic [135:0] m_axis_tdata_o,
  // found[0]
  output logic [0:0]   m_axis_tuser_o,
  // last_row
  output logic         m_axis_tlast_o
);

  ctrl_t              ctrl;
  status_t            status;
  logic               found;
  logic signed [16:0] row_x, row_y;
  logic [63:0]        row_mask;
  logic [23:0]        row_color;
  logic [7:0]         advance;

  // The sequencer steps through the microcode; each control word steers the datapath.
  gbr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  gbr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .mode_i          (s_axis_tuser_i[0]),
    .store_address_i (s_axis_tdata_i[11:0]),
    .store_byte_i    (s_axis_tdata_i[19:12]),
    .origin_x_i      (s_axis_tdata_i[35:20]),
    .origin_y_i      (s_axis_tdata_i[51:36]),
    .char_code_i     (s_axis_tdata_i[59:52]),
    .pixel_color_i   (s_axis_tdata_i[83:60]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .found_o         (found),
    .row_x_o         (row_x),
    .row_y_o         (row_y),
    .row_mask_o      (row_mask),
    .row_color_o     (row_color),
    .advance_o       (advance),
    .last_row_o      (m_axis_tlast_o)
  );

  // Result word packing, lowest field first.
  assign m_axis_tdata_o = {6'd0, advance, row_color, row_mask, row_y, row_x};
  assign m_axis_tuser_o = found;

endmodule
